### rtl/spmm_pkg.sv
package spmm_pkg;

  localparam int unsigned BRows    = 64;
  localparam int unsigned BCols    = 32;
  localparam int unsigned Lanes    = 8;
  localparam int unsigned NumTiles = BCols / Lanes;
  localparam int unsigned BDepth   = BRows * NumTiles;
  localparam int unsigned BAddrW   = $clog2(BDepth);
  localparam int unsigned TileW    = $clog2(NumTiles);

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] PosZero    = 32'h0000_0000;

  typedef logic [Lanes-1:0][31:0] tile_t;

  // Position of the highest set bit.
  function automatic logic [5:0] msb_pos(input logic [50:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Round to nearest even and pack; pn has its leading one at bit 47.
  function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                           input logic [47:0] pn);
    logic [49:0]        w;
    logic [49:0]        mask;
    logic [7:0]         sh;
    logic               lost;
    logic [23:0]        mant;
    logic               g;
    logic               st;
    logic [24:0]        m;
    logic signed [10:0] e2;
    w = {pn, 2'b00};
    if (e < 11'sd1) begin
      sh = (e < -11'sd48) ? 8'd49 : 8'(11'sd1 - e);
      mask = {50{1'b1}} << sh;
      lost = |(w & ~mask);
      w = (w >> sh) | {49'd0, lost};
    end
    mant = w[49:26];
    g = w[25];
    st = |w[24:0];
    m = {1'b0, mant} + {24'd0, g & (st | mant[0])};
    if (e < 11'sd1) begin
      return {s, 7'd0, m[23], m[22:0]};
    end
    e2 = e + {10'd0, m[24]};
    if (e2 > 11'sd254) return {s, 8'hFF, 23'd0};
    return {s, e2[7:0], (m[24] ? m[23:1] : m[22:0])};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic               an, bn, ai, bi, az, bz;
    logic [23:0]        ma, mb;
    logic [7:0]         xa, xb;
    logic [47:0]        p;
    logic [5:0]         l;
    logic signed [10:0] e;
    an = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    ai = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    az = (a[30:0] == '0);
    bz = (b[30:0] == '0);
    s = a[31] ^ b[31];
    if (an) return a | QuietBit;
    if (bn) return b | QuietBit;
    if ((ai && bz) || (bi && az)) return DefaultNan;
    if (ai || bi) return {s, 8'hFF, 23'd0};
    if (az || bz) return {s, 31'd0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p = ma * mb;
    l = msb_pos({3'd0, p});
    e = 11'(xa) + 11'(xb) + 11'(l) - 11'sd173;
    return fp_round(s, e, p << (6'd47 - l));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic        xn, yn, xi, yi;
    logic [31:0] bg, sm;
    logic [7:0]  eb, es, d;
    logic [50:0] wb, ws, mask;
    logic        lost;
    logic [50:0] sum;
    logic [50:0] nrm;
    logic [5:0]  l;
    xn = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    yn = (y[30:23] == 8'hFF) && (y[22:0] != '0);
    xi = (x[30:23] == 8'hFF) && (x[22:0] == '0);
    yi = (y[30:23] == 8'hFF) && (y[22:0] == '0);
    if (xn) return x | QuietBit;
    if (yn) return y | QuietBit;
    if (xi && yi && (x[31] != y[31])) return DefaultNan;
    if (xi) return x;
    if (yi) return y;
    if (x[30:0] < y[30:0]) begin
      bg = y;
      sm = x;
    end else begin
      bg = x;
      sm = y;
    end
    eb = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d = eb - es;
    wb = {1'b0, bg[30:23] != 8'd0, bg[22:0], 26'd0};
    ws = {1'b0, sm[30:23] != 8'd0, sm[22:0], 26'd0};
    if (d > 8'd50) begin
      lost = |ws;
      ws = {50'd0, lost};
    end else begin
      mask = {51{1'b1}} << d;
      lost = |(ws & ~mask);
      ws = (ws >> d) | {50'd0, lost};
    end
    sum = (x[31] == y[31]) ? (wb + ws) : (wb - ws);
    if (sum == '0) return {x[31] & y[31], 31'd0};
    l = msb_pos(sum);
    nrm = sum << (6'd50 - l);
    return fp_round(bg[31], 11'(eb) + 11'(l) - 11'sd49, {nrm[50:4], |nrm[3:0]});
  endfunction

endpackage

### rtl/spmm_ram.sv
module spmm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, register the read word.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/spmm_mac.sv
module spmm_mac (
  input  logic                 clk_i,
  input  logic                 cap_i,
  input  logic [31:0]          a_i,
  input  spmm_pkg::tile_t      b_tile_i,
  input  spmm_pkg::tile_t      acc_tile_i,
  output spmm_pkg::tile_t      sum_tile_o
);
  import spmm_pkg::*;

  tile_t prod_q;

  // Capture eight rounded products.
  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      for (int i = 0; i < Lanes; i++) prod_q[i] <= fp_mul(a_i, b_tile_i[i]);
    end
  end

  // Add products into the accumulator tile.
  always_comb begin
    for (int i = 0; i < Lanes; i++) sum_tile_o[i] = fp_add(acc_tile_i[i], prod_q[i]);
  end

endmodule

### rtl/sparse_dense_matmul_pe_top.sv
// Load beat: written at the accept edge, busy stays low, so loads can follow back to back.
// Nonzero beat: busy after the accept while each tile of the B row passes B read,
// multiply, and add and write back of the accumulator memory; the next beat is taken once idle.
// Row end: after the last tile of the last nonzero, each of the 4 tiles of the row is read and
// then shown on the outputs, in tile order; busy drops after the last tile.
// The receiver cannot stall. Reset clears the sums (tile valid bits), counters, control.
module sparse_dense_matmul_pe_top #(
  parameter int unsigned NNZ_PER_ROW = 8,
  parameter int unsigned A_ROWS      = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [5:0]  b_row_i,
  input  logic [4:0]  b_col_i,
  input  logic [31:0] b_value_i,
  input  logic [5:0]  a_col_index_i,
  input  logic [31:0] a_value_i,
  output logic        valid_o,
  output logic [5:0]  row_index_o,
  output logic [1:0]  tile_index_o,
  output logic [31:0] c_lane0_o,
  output logic [31:0] c_lane1_o,
  output logic [31:0] c_lane2_o,
  output logic [31:0] c_lane3_o,
  output logic [31:0] c_lane4_o,
  output logic [31:0] c_lane5_o,
  output logic [31:0] c_lane6_o,
  output logic [31:0] c_lane7_o,
  output logic        last_tile_o
);
  import spmm_pkg::*;

  localparam int unsigned NW = (NNZ_PER_ROW > 1) ? $clog2(NNZ_PER_ROW) : 1;
  localparam int unsigned RW = (A_ROWS > 1) ? $clog2(A_ROWS) : 1;

  typedef enum logic [2:0] {
    Idle, BRead, Mul, Add, OutRead, Out
  } state_e;

  state_e            state_q;
  logic [TileW-1:0]  tile_q;
  logic [5:0]        idx_q;
  logic [31:0]       a_q;
  logic [NW-1:0]     nz_q;
  logic [RW-1:0]     row_q;
  logic [NumTiles-1:0] vld_q;

  logic              accept;
  logic              load_we;
  tile_t             b_tile;
  tile_t             acc_rd;
  tile_t             acc_in;
  tile_t             sum_tile;
  logic [RW+5:0]     row_w;

  assign accept  = start && !busy;
  assign load_we = accept && !kind_i;
  assign busy    = (state_q != Idle);

  // B store: one RAM per lane, word address {row, tile}.
  for (genvar g = 0; g < Lanes; g++) begin : g_blane
    spmm_ram #(.Width(32), .Depth(BDepth)) u_bram (
      .clk_i   (clk_i),
      .we_i    (load_we && (b_col_i[2:0] == 3'(g))),
      .waddr_i ({b_row_i, b_col_i[4:3]}),
      .wdata_i (b_value_i),
      .raddr_i ({idx_q, tile_q}),
      .rdata_o (b_tile[g])
    );
  end

  // Accumulator memory, one tile per word.
  spmm_ram #(.Width(32 * Lanes), .Depth(NumTiles)) u_acc (
    .clk_i   (clk_i),
    .we_i    (state_q == Add),
    .waddr_i (tile_q),
    .wdata_i (sum_tile),
    .raddr_i (tile_q),
    .rdata_o (acc_rd)
  );

  // Cleared tiles read as positive zero.
  always_comb begin
    for (int i = 0; i < Lanes; i++) acc_in[i] = vld_q[tile_q] ? acc_rd[i] : PosZero;
  end

  spmm_mac u_mac (
    .clk_i      (clk_i),
    .cap_i      (state_q == Mul),
    .a_i        (a_q),
    .b_tile_i   (b_tile),
    .acc_tile_i (acc_in),
    .sum_tile_o (sum_tile)
  );

  // Sequence the tiles of a nonzero and the row drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      tile_q  <= '0;
      nz_q    <= '0;
      row_q   <= '0;
      vld_q   <= '0;
    end else begin
      unique case (state_q)
        Idle: begin
          if (accept && kind_i) begin
            tile_q  <= '0;
            state_q <= BRead;
          end
        end
        BRead: state_q <= Mul;
        Mul:   state_q <= Add;
        Add: begin
          vld_q[tile_q] <= 1'b1;
          tile_q <= tile_q + 1'b1;
          if (tile_q == TileW'(NumTiles - 1)) begin
            if (nz_q == NW'(NNZ_PER_ROW - 1)) begin
              nz_q    <= '0;
              state_q <= OutRead;
            end else begin
              nz_q    <= nz_q + 1'b1;
              state_q <= Idle;
            end
          end else begin
            state_q <= BRead;
          end
        end
        OutRead: state_q <= Out;
        Out: begin
          vld_q[tile_q] <= 1'b0;
          tile_q <= tile_q + 1'b1;
          if (tile_q == TileW'(NumTiles - 1)) begin
            row_q   <= (row_q == RW'(A_ROWS - 1)) ? '0 : row_q + 1'b1;
            state_q <= Idle;
          end else begin
            state_q <= OutRead;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // Hold the nonzero operands.
  always_ff @(posedge clk_i) begin
    if (accept && kind_i) begin
      idx_q <= a_col_index_i;
      a_q   <= a_value_i;
    end
  end

  // Drive the result beat.
  assign row_w        = (RW + 6)'(row_q);
  assign valid_o      = (state_q == Out);
  assign row_index_o  = row_w[5:0];
  assign tile_index_o = 2'(tile_q);
  assign last_tile_o  = (tile_q == TileW'(NumTiles - 1));
  assign c_lane0_o    = acc_in[0];
  assign c_lane1_o    = acc_in[1];
  assign c_lane2_o    = acc_in[2];
  assign c_lane3_o    = acc_in[3];
  assign c_lane4_o    = acc_in[4];
  assign c_lane5_o    = acc_in[5];
  assign c_lane6_o    = acc_in[6];
  assign c_lane7_o    = acc_in[7];

  a_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result beat while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_tile_o |=> !valid_o && !busy) else $error("drain did not end");
  a_next_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_tile_o |=> !valid_o ##1 valid_o) else $error("tile beat missing");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_we |=> !busy) else $error("load made the block busy");

endmodule
